[sv/assert_macros.svh]
// Assertion macros shared by the voxel boundary extractor RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[sv/vbe_pkg.sv]
// Package for the voxel boundary extractor: sizes, register indexes,
// sequencer states and helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vbe_pkg;

    // Volume geometry and voxel width.
    localparam int MAX_DIM    = 64;
    localparam int VOXEL_BITS = 16;
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int COORD_W    = $clog2(MAX_DIM);
    localparam int ADDR_W     = 3 * COORD_W;
    localparam int VOL_DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int INSIDE_W   = 15;
    localparam int AREA_W     = 2 * COORD_W + 1;
    localparam int PROD_W     = AREA_W + DIM_W;
    localparam int NB_LAST    = 6;
    localparam int K_W        = 3;

    // Stream payload widths.
    localparam int OUT_DATA_W = 24;
    localparam int IN_DATA_W  = 16;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_DIM_X  = 2'd0,
        REG_DIM_Y  = 2'd1,
        REG_DIM_Z  = 2'd2,
        REG_INSIDE = 2'd3
    } reg_idx_t;

    // Read slots of one voxel test: the voxel itself, then its six faces.
    typedef enum logic [K_W-1:0] {
        NB_CENTER = 3'd0,
        NB_XM     = 3'd1,
        NB_YM     = 3'd2,
        NB_ZM     = 3'd3,
        NB_XP     = 3'd4,
        NB_YP     = 3'd5,
        NB_ZP     = 3'd6
    } nb_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_AREA,
        ST_LD_TOTAL,
        ST_LD_WRITE,
        ST_F_AREA,
        ST_F_CAP,
        ST_STEP,
        ST_MUL_Y,
        ST_MUL_Z,
        ST_ADDR,
        ST_READ,
        ST_DRAIN,
        ST_EVAL,
        ST_EMIT
    } state_t;

    // Clamp a configured dimension into 1..MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        begin
            r = d;
            if (d == '0)
            begin
                r = DIM_W'(1);
            end
            else if (d > DIM_W'(MAX_DIM))
            begin
                r = DIM_W'(MAX_DIM);
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

[sv/voxel_boundary_extractor.sv]
// Voxel boundary extractor: 3-D voxel store with a sequenced 6-neighbor scan.
// Depends on vbe_pkg, vbe_ram and assert_macros.svh.
// A load passes through ST_LD_AREA, ST_LD_TOTAL and ST_LD_WRITE. A fetch computes the area in
// ST_F_AREA and ST_F_CAP, tests each voxel with up to seven reads through the single RAM read
// port, takes a ST_STEP turn per row, column or end of scan and posts the result in ST_EMIT. One transaction at a time.
// Reset clears the sequencer, load index, scan position and registers; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module voxel_boundary_extractor (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Input stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [vbe_pkg::IN_DATA_W-1:0] s_axis_tdata,  // [15:0] voxel
    input  wire logic [0:0]                   s_axis_tuser,   // [0] kind
    // Output stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [vbe_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [5:0] coord_x, [11:6] coord_y,
                                                              // [17:12] coord_z, [23:18] zero
    output logic [0:0]                        m_axis_tuser,   // [0] found
    // Configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [vbe_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [vbe_pkg::PDATA_W-1:0]  pwdata,
    output logic      [vbe_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    import vbe_pkg::*;

    // Configuration registers.
    logic [DIM_W-1:0]    dim_x_reg, dim_y_reg, dim_z_reg;
    logic [INSIDE_W-1:0] inside_reg;
    logic [DIM_W-1:0]    dx, dy, dz;
    reg_idx_t            reg_sel;
    logic                cfg_wr;

    // Sequencer and datapath state.
    state_t              state_reg, state_next;
    logic [VOXEL_BITS-1:0] voxel_reg;
    logic [ADDR_W-1:0]   load_index_reg;
    logic [DIM_W-1:0]    scan_x_reg, scan_y_reg, scan_z_reg;
    logic                finished_reg;
    logic [AREA_W-1:0]   area_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ADDR_W-1:0]   base_reg, center_reg;
    logic [K_W-1:0]      k_reg;
    logic                pend_reg, pend_center_reg;
    logic                center_ok_reg, nb_diff_reg, outside_reg;
    logic [COORD_W-1:0]  res_x_reg, res_y_reg, res_z_reg;
    logic                res_found_reg;
    logic                m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                m_found_reg;

    // Shared multiplier operands.
    logic [AREA_W-1:0]   mul_a;
    logic [DIM_W-1:0]    mul_b;

    // Sequencer outputs.
    logic                in_accept;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic                rd_issue;
    logic                nb_outside;
    logic [VOXEL_BITS-1:0] ram_rdata;
    logic [ADDR_W:0]     total;
    logic [ADDR_W-1:0]   load_slot;
    logic [ADDR_W:0]     load_after;
    logic                emit_ok;
    logic                hit;

    assign dx = eff_dim(dim_x_reg);
    assign dy = eff_dim(dim_y_reg);
    assign dz = eff_dim(dim_z_reg);

    // APB decode; pready is tied high.
    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_sel)
            REG_DIM_X:  prdata = PDATA_W'(dim_x_reg);
            REG_DIM_Y:  prdata = PDATA_W'(dim_y_reg);
            REG_DIM_Z:  prdata = PDATA_W'(dim_z_reg);
            REG_INSIDE: prdata = PDATA_W'(inside_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg  <= DIM_W'(MAX_DIM);
            dim_y_reg  <= DIM_W'(MAX_DIM);
            dim_z_reg  <= DIM_W'(MAX_DIM);
            inside_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_DIM_X:  dim_x_reg  <= pwdata[DIM_W-1:0];
                REG_DIM_Y:  dim_y_reg  <= pwdata[DIM_W-1:0];
                REG_DIM_Z:  dim_z_reg  <= pwdata[DIM_W-1:0];
                REG_INSIDE: inside_reg <= pwdata[INSIDE_W-1:0];
                default:    ;
            endcase
        end
    end

    // Stream handshakes.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign emit_ok       = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_found_reg;

    // Load slot: wrap to zero when the index lies beyond the volume in use.
    assign total      = prod_reg[ADDR_W:0];
    assign load_slot  = ({1'b0, load_index_reg} >= total) ? '0 : load_index_reg;
    assign load_after = {1'b0, load_slot} + (ADDR_W+1)'(1);

    // A voxel is on the boundary when it matches and some face differs or leaves the volume.
    assign hit = center_ok_reg && (nb_diff_reg || outside_reg);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = s_axis_tuser[0] ? ST_F_AREA : ST_LD_AREA;
                end
            end
            ST_LD_AREA:  state_next = ST_LD_TOTAL;
            ST_LD_TOTAL: state_next = ST_LD_WRITE;
            ST_LD_WRITE: state_next = ST_IDLE;
            ST_F_AREA:   state_next = ST_F_CAP;
            ST_F_CAP:    state_next = ST_STEP;
            ST_STEP:
            begin
                if (finished_reg || scan_x_reg >= dx)
                begin
                    state_next = ST_EMIT;
                end
                else if (scan_y_reg < dy && scan_z_reg < dz)
                begin
                    state_next = ST_MUL_Y;
                end
            end
            ST_MUL_Y:    state_next = ST_MUL_Z;
            ST_MUL_Z:    state_next = ST_ADDR;
            ST_ADDR:     state_next = ST_READ;
            ST_READ:
            begin
                if (k_reg == K_W'(NB_LAST))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:    state_next = ST_EVAL;
            ST_EVAL:     state_next = hit ? ST_EMIT : ST_STEP;
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Output logic: multiplier operands, RAM ports and neighbor selection.
    always_comb
    begin
        mul_a      = '0;
        mul_b      = '0;
        ram_we     = 1'b0;
        ram_waddr  = load_slot;
        ram_raddr  = center_reg;
        rd_issue   = 1'b0;
        nb_outside = 1'b0;
        case (state_reg)
            ST_LD_AREA, ST_F_AREA:
            begin
                mul_a = AREA_W'(dx);
                mul_b = dy;
            end
            ST_LD_TOTAL:
            begin
                mul_a = prod_reg[AREA_W-1:0];
                mul_b = dz;
            end
            ST_LD_WRITE:
            begin
                ram_we = 1'b1;
            end
            ST_MUL_Y:
            begin
                mul_a = AREA_W'(dx);
                mul_b = scan_y_reg;
            end
            ST_MUL_Z:
            begin
                mul_a = area_reg;
                mul_b = scan_z_reg;
            end
            ST_READ:
            begin
                case (nb_t'(k_reg))
                    NB_CENTER:
                    begin
                        ram_raddr = center_reg;
                    end
                    NB_XM:
                    begin
                        nb_outside = (scan_x_reg == '0);
                        ram_raddr  = center_reg - ADDR_W'(1);
                    end
                    NB_YM:
                    begin
                        nb_outside = (scan_y_reg == '0);
                        ram_raddr  = center_reg - ADDR_W'(dx);
                    end
                    NB_ZM:
                    begin
                        nb_outside = (scan_z_reg == '0);
                        ram_raddr  = center_reg - ADDR_W'(area_reg);
                    end
                    NB_XP:
                    begin
                        nb_outside = (scan_x_reg + DIM_W'(1) >= dx);
                        ram_raddr  = center_reg + ADDR_W'(1);
                    end
                    NB_YP:
                    begin
                        nb_outside = (scan_y_reg + DIM_W'(1) >= dy);
                        ram_raddr  = center_reg + ADDR_W'(dx);
                    end
                    NB_ZP:
                    begin
                        nb_outside = (scan_z_reg + DIM_W'(1) >= dz);
                        ram_raddr  = center_reg + ADDR_W'(area_reg);
                    end
                    default:
                    begin
                        nb_outside = 1'b0;
                    end
                endcase
                rd_issue = !nb_outside;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Voxel store.
    vbe_ram #(
        .WIDTH (VOXEL_BITS),
        .DEPTH (VOL_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (voxel_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared multiplier with its product register, and payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (in_accept)
        begin
            voxel_reg <= s_axis_tdata[VOXEL_BITS-1:0];
        end
        if (state_reg == ST_F_CAP)
        begin
            area_reg <= prod_reg[AREA_W-1:0];
        end
        if (state_reg == ST_MUL_Z)
        begin
            base_reg <= prod_reg[ADDR_W-1:0] + ADDR_W'(scan_x_reg);
        end
        if (state_reg == ST_ADDR)
        begin
            center_reg <= base_reg + prod_reg[ADDR_W-1:0];
        end
    end

    // Sequencer state, scan position, read checks and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            load_index_reg  <= '0;
            scan_x_reg      <= '0;
            scan_y_reg      <= '0;
            scan_z_reg      <= '0;
            finished_reg    <= 1'b0;
            k_reg           <= '0;
            pend_reg        <= 1'b0;
            pend_center_reg <= 1'b0;
            center_ok_reg   <= 1'b0;
            nb_diff_reg     <= 1'b0;
            outside_reg     <= 1'b0;
            res_x_reg       <= '0;
            res_y_reg       <= '0;
            res_z_reg       <= '0;
            res_found_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
            m_data_reg      <= '0;
            m_found_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Store one voxel and rewind the scan.
            if (state_reg == ST_LD_WRITE)
            begin
                load_index_reg <= (load_after >= total) ? '0 : load_after[ADDR_W-1:0];
                scan_x_reg     <= '0;
                scan_y_reg     <= '0;
                scan_z_reg     <= '0;
                finished_reg   <= 1'b0;
            end

            // Walk the nested x, y, z loops.
            if (state_reg == ST_STEP)
            begin
                if (finished_reg)
                begin
                    res_found_reg <= 1'b0;
                    res_x_reg     <= '0;
                    res_y_reg     <= '0;
                    res_z_reg     <= '0;
                end
                else if (scan_x_reg >= dx)
                begin
                    finished_reg  <= 1'b1;
                    scan_x_reg    <= '0;
                    scan_y_reg    <= '0;
                    scan_z_reg    <= '0;
                    res_found_reg <= 1'b0;
                    res_x_reg     <= '0;
                    res_y_reg     <= '0;
                    res_z_reg     <= '0;
                end
                else if (scan_y_reg >= dy)
                begin
                    scan_y_reg <= '0;
                    scan_z_reg <= '0;
                    scan_x_reg <= scan_x_reg + DIM_W'(1);
                end
                else if (scan_z_reg >= dz)
                begin
                    scan_z_reg <= '0;
                    scan_y_reg <= scan_y_reg + DIM_W'(1);
                end
            end

            // Clear the test flags before the reads of a voxel.
            if (state_reg == ST_ADDR)
            begin
                k_reg         <= '0;
                center_ok_reg <= 1'b0;
                nb_diff_reg   <= 1'b0;
                outside_reg   <= 1'b0;
            end

            // Issue one read per cycle, skipping faces outside the volume.
            if (state_reg == ST_READ)
            begin
                k_reg           <= k_reg + K_W'(1);
                pend_reg        <= rd_issue;
                pend_center_reg <= (nb_t'(k_reg) == NB_CENTER);
                if (nb_outside)
                begin
                    outside_reg <= 1'b1;
                end
            end
            else
            begin
                pend_reg <= 1'b0;
            end

            // Compare the data of the read issued in the previous cycle.
            if (pend_reg)
            begin
                if (pend_center_reg)
                begin
                    center_ok_reg <= (ram_rdata == VOXEL_BITS'(inside_reg));
                end
                else if (ram_rdata != VOXEL_BITS'(inside_reg))
                begin
                    nb_diff_reg <= 1'b1;
                end
            end

            // Finish one voxel test.
            if (state_reg == ST_EVAL)
            begin
                scan_z_reg <= scan_z_reg + DIM_W'(1);
                if (hit)
                begin
                    res_found_reg <= 1'b1;
                    res_x_reg     <= scan_x_reg[COORD_W-1:0];
                    res_y_reg     <= scan_y_reg[COORD_W-1:0];
                    res_z_reg     <= scan_z_reg[COORD_W-1:0];
                end
            end

            // Output register.
            if (state_reg == ST_EMIT && emit_ok)
            begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= OUT_DATA_W'({res_z_reg, res_y_reg, res_x_reg});
                m_found_reg <= res_found_reg;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Assertions.
    `ASSERT_IMP(a_notfound_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)
    `ASSERT_IMP(a_pend_in_read, clk, rst_n, pend_reg, state_reg == ST_READ || state_reg == ST_DRAIN)
    `ASSERT_IMP(a_k_range, clk, rst_n, state_reg == ST_READ, k_reg <= K_W'(NB_LAST))
    `ASSERT_NXT(a_eval_after_drain, clk, rst_n, state_reg == ST_DRAIN, state_reg == ST_EVAL && !pend_reg)

endmodule

`default_nettype wire

[sv/vbe_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vbe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
